// File: sv/dncc_pkg.sv
`timescale 1ns / 1ps
// Package for the day number calendar converter.
// Field widths, operation codes, reciprocal constants and the month term table.
// No dependencies.

package dncc_pkg;

  localparam int unsigned OP_W   = 1;
  localparam int unsigned DN_W   = 16;
  localparam int unsigned SEC_W  = 17;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 12;
  localparam int unsigned PACK_W = 25;

  localparam logic [OP_W-1:0] OP_TO_DATE = 1'b0;
  localparam logic [OP_W-1:0] OP_TO_DAY  = 1'b1;

  localparam logic [SEC_W-1:0] SEC_LAST = 17'd86399;
  localparam logic [DN_W-1:0]  DN_LAST  = 16'hFFFF;

  // Julian day of day 0 plus the first offset of the forward formula
  localparam logic [21:0] L_OFFSET = 22'd2510982;

  // 400-year cycle boundaries, (146097 * n + 3) / 4
  localparam logic [21:0] CYC_BASE_68 = 22'((68 * 146097 + 3) / 4);
  localparam logic [21:0] CYC_BASE_69 = 22'((69 * 146097 + 3) / 4);
  localparam logic [21:0] CYC_BASE_70 = 22'((70 * 146097 + 3) / 4);

  localparam logic [YEAR_W-1:0] YEAR_BASE = 12'd1900;

  // 32075 + 2442413
  localparam logic [23:0] JDN_BIAS = 24'd2474488;

  // floor(x * A / D) == (x * ceil(2^S * A / D)) >> S while x * D < 2^S
  localparam int unsigned I_SHIFT = 37;
  localparam logic [28:0] I_MULT =
    29'(((64'd1 << I_SHIFT) * 64'd4000 + 64'd1461000) / 64'd1461001);

  localparam int unsigned J_SHIFT = 22;
  localparam logic [17:0] J_MULT =
    18'(((64'd1 << J_SHIFT) * 64'd80 + 64'd2446) / 64'd2447);

  localparam int unsigned DD_SHIFT = 13;
  localparam logic [17:0] DD_MULT =
    18'(((64'd1 << DD_SHIFT) * 64'd2447 + 64'd79) / 64'd80);

  localparam int unsigned HH_SHIFT = 29;
  localparam logic [17:0] HH_MULT =
    18'(((64'd1 << HH_SHIFT) + 64'd3599) / 64'd3600);

  localparam int unsigned MM_SHIFT = 18;
  localparam logic [12:0] MM_MULT =
    13'(((64'd1 << MM_SHIFT) + 64'd59) / 64'd60);

  localparam int unsigned Q_SHIFT = 20;
  localparam logic [13:0] Q_MULT =
    14'(((64'd1 << Q_SHIFT) + 64'd99) / 64'd100);

  // (367 * (m - 2 - 12 * a)) / 12, a = -1 for months 0 to 2
  function automatic logic [8:0] month_term(input logic [MON_W-1:0] m);
    logic [8:0] t;
    case (m)
      4'd0:    t = 9'd305;
      4'd1:    t = 9'd336;
      4'd2:    t = 9'd367;
      4'd3:    t = 9'd30;
      4'd4:    t = 9'd61;
      4'd5:    t = 9'd91;
      4'd6:    t = 9'd122;
      4'd7:    t = 9'd152;
      4'd8:    t = 9'd183;
      4'd9:    t = 9'd214;
      4'd10:   t = 9'd244;
      4'd11:   t = 9'd275;
      4'd12:   t = 9'd305;
      4'd13:   t = 9'd336;
      4'd14:   t = 9'd367;
      default: t = 9'd397;
    endcase
    return t;
  endfunction

endpackage

// File: sv/dncc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the day number calendar converter.
// Depends on dncc_pkg.

interface dncc_in_if import dncc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DN_W-1:0]   day_number;
  logic [SEC_W-1:0]  seconds_of_day;
  logic [DAY_W-1:0]  cal_day;
  logic [MON_W-1:0]  cal_month;
  logic [YEAR_W-1:0] cal_year;

  modport source (
    output valid, op, day_number, seconds_of_day, cal_day, cal_month, cal_year,
    input  ready
  );
  modport sink (
    input  valid, op, day_number, seconds_of_day, cal_day, cal_month, cal_year,
    output ready
  );
endinterface

interface dncc_out_if import dncc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PACK_W-1:0] packed_date;
  logic [PACK_W-1:0] packed_time;
  logic [DN_W-1:0]   day_number_out;
  logic              out_of_range;

  modport source (
    output valid, packed_date, packed_time, day_number_out, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, packed_date, packed_time, day_number_out, out_of_range,
    output ready
  );
endinterface

// File: sv/day_number_calendar_converter.sv
`timescale 1ns / 1ps
// Day number calendar converter, top level. Depends on dncc_pkg and dncc_if.
// req_i (dncc_in_if.sink) takes one transaction per conversion request:
//   op 0 turns day_number and seconds_of_day into binary values that read yyyymmdd and
//   hhmmss00 in decimal; op 1 turns cal_day, cal_month and cal_year into a day number,
//   saturated to 0..65535 with out_of_range set when clipped.
// rsp_o (dncc_out_if.source) returns exactly one transaction per request,
//   in order; fields that do not belong to the operation are zero.
// Throughput is one transaction per cycle while rsp_o.ready is high, set by a
//   seven-stage pipeline with the constant multiplies spread over the stages
//   (reciprocal multiplies stand in for the divisions).
// When rsp_o.ready is low, data holds in the output stage and bubbles ahead of
//   it still close up; req_i.ready falls only when every stage is full.
// Reset clears all stage valid bits; no transaction is in flight afterwards.

module day_number_calendar_converter import dncc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dncc_in_if.sink     req_i,
  dncc_out_if.source  rsp_o
);

  localparam int unsigned NSTG = 7;

  logic [NSTG:1] vld_q;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = ~vld_q[NSTG] | rsp_o.ready;
    for (int s = NSTG - 1; s >= 1; s--) begin
      adv[s] = ~vld_q[s] | adv[s+1];
    end
  end

  assign req_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= req_i.valid;
      for (int s = 2; s <= NSTG; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // stage 1: cycle split, seconds clamp, calendar products
  logic [21:0]      l_w;
  logic [21:0]      cyc_base;
  logic [1:0]       nsel_d;
  logic [SEC_W-1:0] secs_d;
  logic             jan_feb;
  logic [13:0]      v1, v2;
  logic [23:0]      t1_prod;
  logic [27:0]      q_prod;

  always_comb begin
    l_w = 22'(req_i.day_number) + L_OFFSET;
    if (l_w >= CYC_BASE_70) begin
      nsel_d   = 2'd2;
      cyc_base = CYC_BASE_70;
    end else if (l_w >= CYC_BASE_69) begin
      nsel_d   = 2'd1;
      cyc_base = CYC_BASE_69;
    end else begin
      nsel_d   = 2'd0;
      cyc_base = CYC_BASE_68;
    end
    secs_d  = (req_i.seconds_of_day > SEC_LAST) ? SEC_LAST : req_i.seconds_of_day;
    jan_feb = req_i.cal_month inside {[4'd0:4'd2]};
    v1      = 14'(req_i.cal_year) + 14'd4800 - 14'(jan_feb);
    v2      = 14'(req_i.cal_year) + 14'd4900 - 14'(jan_feb);
    t1_prod = 24'(v1) * 24'd1461;
    q_prod  = 28'(v2) * 28'(Q_MULT);
  end

  logic [OP_W-1:0]  s1_op_q;
  logic [15:0]      s1_l2_q;
  logic [1:0]       s1_nsel_q;
  logic [SEC_W-1:0] s1_secs_q;
  logic [21:0]      s1_t1_q;
  logic [6:0]       s1_q_q;
  logic [8:0]       s1_t2_q;
  logic [DAY_W-1:0] s1_d_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_op_q   <= req_i.op;
      s1_l2_q   <= 16'(l_w - cyc_base);
      s1_nsel_q <= nsel_d;
      s1_secs_q <= secs_d;
      s1_t1_q   <= t1_prod[23:2];
      s1_q_q    <= q_prod[Q_SHIFT +: 7];
      s1_t2_q   <= month_term(req_i.cal_month);
      s1_d_q    <= req_i.cal_day;
    end
  end

  // stage 2: year in cycle, hours, day number sum
  logic [44:0] i_prod;
  logic [34:0] hh_prod;
  logic [8:0]  t3_w;
  logic [23:0] r_d;

  always_comb begin
    i_prod  = (45'(s1_l2_q) + 45'd1) * 45'(I_MULT);
    hh_prod = 35'(s1_secs_q) * 35'(HH_MULT);
    t3_w    = 9'(s1_q_q) * 9'd3;
    r_d     = 24'(s1_t1_q) + 24'(s1_t2_q) + 24'(s1_d_q) - 24'(t3_w[8:2]) - JDN_BIAS;
  end

  logic [OP_W-1:0]  s2_op_q;
  logic [15:0]      s2_l2_q;
  logic [1:0]       s2_nsel_q;
  logic [6:0]       s2_i_q;
  logic [SEC_W-1:0] s2_secs_q;
  logic [4:0]       s2_hh_q;
  logic [23:0]      s2_r_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_op_q   <= s1_op_q;
      s2_l2_q   <= s1_l2_q;
      s2_nsel_q <= s1_nsel_q;
      s2_i_q    <= i_prod[I_SHIFT +: 7];
      s2_secs_q <= s1_secs_q;
      s2_hh_q   <= hh_prod[HH_SHIFT +: 5];
      s2_r_q    <= r_d;
    end
  end

  // stage 3: day in year, seconds within hour, saturation
  logic [17:0]     y_days;
  logic [16:0]     l3_w;
  logic [16:0]     rem_w;
  logic [DN_W-1:0] dno_d;
  logic            oor_d;

  always_comb begin
    y_days = 18'(s2_i_q) * 18'd1461;
    l3_w   = 17'(s2_l2_q) + 17'd31 - 17'(y_days[17:2]);
    rem_w  = s2_secs_q - 17'(s2_hh_q) * 17'd3600;
    if (s2_r_q[23]) begin
      dno_d = '0;
      oor_d = 1'b1;
    end else if (s2_r_q[22:16] != 7'd0) begin
      dno_d = DN_LAST;
      oor_d = 1'b1;
    end else begin
      dno_d = s2_r_q[15:0];
      oor_d = 1'b0;
    end
  end

  logic [OP_W-1:0] s3_op_q;
  logic [9:0]      s3_l3_q;
  logic [1:0]      s3_nsel_q;
  logic [6:0]      s3_i_q;
  logic [11:0]     s3_rem_q;
  logic [4:0]      s3_hh_q;
  logic [DN_W-1:0] s3_dno_q;
  logic            s3_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_op_q   <= s2_op_q;
      s3_l3_q   <= l3_w[9:0];
      s3_nsel_q <= s2_nsel_q;
      s3_i_q    <= s2_i_q;
      s3_rem_q  <= rem_w[11:0];
      s3_hh_q   <= s2_hh_q;
      s3_dno_q  <= dno_d;
      s3_oor_q  <= oor_d;
    end
  end

  // stage 4: month index, minutes
  logic [27:0] j_prod;
  logic [24:0] mm_prod;

  always_comb begin
    j_prod  = 28'(s3_l3_q) * 28'(J_MULT);
    mm_prod = 25'(s3_rem_q) * 25'(MM_MULT);
  end

  logic [OP_W-1:0] s4_op_q;
  logic [9:0]      s4_l3_q;
  logic [1:0]      s4_nsel_q;
  logic [6:0]      s4_i_q;
  logic [5:0]      s4_j_q;
  logic [11:0]     s4_rem_q;
  logic [4:0]      s4_hh_q;
  logic [5:0]      s4_mm_q;
  logic [DN_W-1:0] s4_dno_q;
  logic            s4_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_op_q   <= s3_op_q;
      s4_l3_q   <= s3_l3_q;
      s4_nsel_q <= s3_nsel_q;
      s4_i_q    <= s3_i_q;
      s4_j_q    <= j_prod[J_SHIFT +: 6];
      s4_rem_q  <= s3_rem_q;
      s4_hh_q   <= s3_hh_q;
      s4_mm_q   <= mm_prod[MM_SHIFT +: 6];
      s4_dno_q  <= s3_dno_q;
      s4_oor_q  <= s3_oor_q;
    end
  end

  // stage 5: day, month, year, seconds
  logic [23:0]       dd_prod;
  logic [10:0]       dd_w;
  logic              k_w;
  logic [5:0]        mo_w;
  logic [YEAR_W-1:0] yy_w;
  logic [11:0]       ss_w;

  always_comb begin
    dd_prod = 24'(s4_j_q) * 24'(DD_MULT);
    dd_w    = 11'(s4_l3_q) - dd_prod[DD_SHIFT +: 11];
    k_w     = (s4_j_q >= 6'd11);
    mo_w    = s4_j_q + 6'd2 - (k_w ? 6'd12 : 6'd0);
    yy_w    = YEAR_BASE + 12'(s4_nsel_q) * 12'd100 + 12'(s4_i_q) + 12'(k_w);
    ss_w    = s4_rem_q - 12'(s4_mm_q) * 12'd60;
  end

  logic [OP_W-1:0]   s5_op_q;
  logic [DAY_W-1:0]  s5_dd_q;
  logic [3:0]        s5_mo_q;
  logic [YEAR_W-1:0] s5_yy_q;
  logic [4:0]        s5_hh_q;
  logic [5:0]        s5_mm_q;
  logic [5:0]        s5_ss_q;
  logic [DN_W-1:0]   s5_dno_q;
  logic              s5_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_op_q  <= s4_op_q;
      s5_dd_q  <= dd_w[DAY_W-1:0];
      s5_mo_q  <= mo_w[3:0];
      s5_yy_q  <= yy_w;
      s5_hh_q  <= s4_hh_q;
      s5_mm_q  <= s4_mm_q;
      s5_ss_q  <= ss_w[5:0];
      s5_dno_q <= s4_dno_q;
      s5_oor_q <= s4_oor_q;
    end
  end

  // stage 6: decimal weights
  logic [OP_W-1:0]   s6_op_q;
  logic [PACK_W-1:0] s6_ya_q;
  logic [10:0]       s6_md_q;
  logic [PACK_W-1:0] s6_ha_q;
  logic [19:0]       s6_ms_q;
  logic [DN_W-1:0]   s6_dno_q;
  logic              s6_oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_op_q  <= s5_op_q;
      s6_ya_q  <= 25'(s5_yy_q) * 25'd10000;
      s6_md_q  <= 11'(s5_mo_q) * 11'd100 + 11'(s5_dd_q);
      s6_ha_q  <= 25'(s5_hh_q) * 25'd1000000;
      s6_ms_q  <= 20'(s5_mm_q) * 20'd10000 + 20'(s5_ss_q) * 20'd100;
      s6_dno_q <= s5_dno_q;
      s6_oor_q <= s5_oor_q;
    end
  end

  // stage 7: output register
  logic [PACK_W-1:0] date_q;
  logic [PACK_W-1:0] time_q;
  logic [DN_W-1:0]   dno_q;
  logic              oor_q;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      if (s6_op_q == OP_TO_DAY) begin
        date_q <= '0;
        time_q <= '0;
        dno_q  <= s6_dno_q;
        oor_q  <= s6_oor_q;
      end else begin
        date_q <= s6_ya_q + 25'(s6_md_q);
        time_q <= s6_ha_q + 25'(s6_ms_q);
        dno_q  <= '0;
        oor_q  <= 1'b0;
      end
    end
  end

  assign rsp_o.valid          = vld_q[NSTG];
  assign rsp_o.packed_date    = date_q;
  assign rsp_o.packed_time    = time_q;
  assign rsp_o.day_number_out = dno_q;
  assign rsp_o.out_of_range   = oor_q;

endmodule
